/* sv/das_pkg.sv */
package das_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int SCORE_W      = 32;
    localparam int POS_W        = 6;

    // One chain entry: the sortable key and the arrival position behind it.
    typedef struct packed {
        logic               valid;
        logic [SCORE_W-1:0] key;
        logic [POS_W-1:0]   pos;
    } t_entry;

    // Control broadcast to every cell of the chain.
    typedef struct packed {
        logic insert_en;
        logic drain_shift;
    } t_ctrl;

    // Map an IEEE bit pattern onto an unsigned key that follows the total order.
    function automatic logic [SCORE_W-1:0] order_key(input logic [SCORE_W-1:0] bits);
        logic [SCORE_W-1:0] key;
        if (bits[SCORE_W-1]) begin
            key = ~bits;
        end else begin
            key = bits | {1'b1, {(SCORE_W-1){1'b0}}};
        end
        return key;
    endfunction

endpackage

/* sv/das_if.sv */
interface das_in_if;
    logic                       valid;
    logic                       ready;
    logic [das_pkg::SCORE_W-1:0] score;
    logic                       final_item;

    modport source (output valid, output score, output final_item, input ready);
    modport sink   (input valid, input score, input final_item, output ready);
endinterface

interface das_out_if;
    logic                      valid;
    logic                      ready;
    logic [das_pkg::POS_W-1:0] position;
    logic                      final_rank;

    modport source (output valid, output position, output final_rank, input ready);
    modport sink   (input valid, input position, input final_rank, output ready);
endinterface

/* sv/descending_argsort.sv */
// Channel   Dir   Word                      Handshake
// i_in      in    score, final_item         valid/ready
// o_out     out   position, final_rank      valid/ready
//
// Load: one score word a cycle; every cell compares against it at once and the
// chain shifts down by one cell from the insertion point, so an insert is a single step.
// Drain: after the final word, the chain shifts up one cell per taken output word;
// i_in.ready stays low until every word of the run has been taken.
// Reset (synchronous, active low) empties every cell and clears the run count.
// A stall on o_out holds the chain; words past CAPACITY are dropped.
module descending_argsort #(
    parameter int CAPACITY = das_pkg::CAPACITY_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    das_in_if.sink    i_in,
    das_out_if.source o_out
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    das_pkg::t_entry w_entry [CAPACITY];
    logic            w_take  [CAPACITY];
    das_pkg::t_entry w_new;
    das_pkg::t_ctrl  w_ctrl;

    logic             r_draining;
    logic [CNT_W-1:0] r_count;
    logic             w_accept;
    logic             w_full;

    // Hold off input while the chain drains.
    assign i_in.ready = !r_draining;
    assign w_accept   = i_in.valid && i_in.ready;
    // Drop a word once the last cell is occupied.
    assign w_full     = w_entry[CAPACITY-1].valid;

    always_comb begin
        w_new.valid = 1'b1;
        w_new.key   = das_pkg::order_key(i_in.score);
        w_new.pos   = das_pkg::POS_W'(r_count);
    end

    always_comb begin
        w_ctrl.insert_en   = w_accept && !w_full;
        w_ctrl.drain_shift = r_draining && o_out.ready;
    end

    // Head of the chain is the output register.
    assign o_out.valid      = r_draining && w_entry[0].valid;
    assign o_out.position   = w_entry[0].pos;
    assign o_out.final_rank = !w_entry[1].valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_draining <= 1'b0;
            r_count    <= '0;
        end else begin
            if (w_accept && i_in.final_item) begin
                // End the run: start draining, restart the arrival count.
                r_draining <= 1'b1;
                r_count    <= '0;
            end else if (w_ctrl.insert_en) begin
                r_count <= r_count + CNT_W'(1);
            end
            // Stop once the lowest-ranked word leaves.
            if (w_ctrl.drain_shift && !w_entry[1].valid) begin
                r_draining <= 1'b0;
            end
        end
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        das_pkg::t_entry w_prev;
        das_pkg::t_entry w_next;
        logic            w_prev_take;

        if (g == 0) begin : g_head
            assign w_prev      = '0;
            assign w_prev_take = 1'b0;
        end else begin : g_body
            assign w_prev      = w_entry[g-1];
            assign w_prev_take = w_take[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign w_next = '0;
        end else begin : g_link
            assign w_next = w_entry[g+1];
        end

        das_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctrl      (w_ctrl),
            .i_new       (w_new),
            .i_prev      (w_prev),
            .i_prev_take (w_prev_take),
            .i_next      (w_next),
            .o_take      (w_take[g]),
            .o_entry     (w_entry[g])
        );
    end

endmodule

/* sv/das_cell.sv */
module das_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  das_pkg::t_ctrl  i_ctrl,
    input  das_pkg::t_entry i_new,
    input  das_pkg::t_entry i_prev,
    input  logic            i_prev_take,
    input  das_pkg::t_entry i_next,
    output logic            o_take,
    output das_pkg::t_entry o_entry
);

    logic                        r_valid;
    logic [das_pkg::SCORE_W-1:0] r_key;
    logic [das_pkg::POS_W-1:0]   r_pos;
    logic                        w_take;

    // Strict compare: an equal key stays above the newcomer.
    assign w_take = !r_valid || (r_key < i_new.key);
    assign o_take = w_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.drain_shift) begin
            r_valid <= i_next.valid;
        end else if (i_ctrl.insert_en) begin
            // Advance the neighbor's entry, empty or not; else take the newcomer.
            if (i_prev_take) begin
                r_valid <= i_prev.valid;
            end else if (w_take) begin
                r_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.drain_shift) begin
            r_key <= i_next.key;
            r_pos <= i_next.pos;
        end else if (i_ctrl.insert_en) begin
            if (i_prev_take) begin
                r_key <= i_prev.key;
                r_pos <= i_prev.pos;
            end else if (w_take) begin
                r_key <= i_new.key;
                r_pos <= i_new.pos;
            end
        end
    end

    always_comb begin
        o_entry.valid = r_valid;
        o_entry.key   = r_key;
        o_entry.pos   = r_pos;
    end

endmodule
